// ===== rtl/arpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// arpsd_pkg
// Types and constants shared by the ARP scan detector: item structs, result
// status codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package arpsd_pkg;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CFG_SCAN_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_LOOPBACK_OCTET = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_MULTICAST_LOW  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_MULTICAST_HIGH = 8'd3;

   localparam logic [8:0] RST_SCAN_THRESHOLD = 9'd16;
   localparam logic [7:0] RST_LOOPBACK_OCTET = 8'd127;
   localparam logic [7:0] RST_MULTICAST_LOW  = 8'd223;
   localparam logic [7:0] RST_MULTICAST_HIGH = 8'd240;

   localparam logic [8:0] COUNT_MAX = 9'd256;

   localparam logic [2:0] ST_IGNORED  = 3'd0;
   localparam logic [2:0] ST_FLAGGED  = 3'd1;
   localparam logic [2:0] ST_NEW      = 3'd2;
   localparam logic [2:0] ST_UPDATED  = 3'd3;
   localparam logic [2:0] ST_REPORTED = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;

   typedef struct packed {
      logic [31:0] app_id;
      logic [31:0] next_hop;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        report_valid;
      logic [31:0] reported_id;
      logic [8:0]  distinct_count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/arp_scan_detector.sv =====
// ----------------------------------------------------------------------------
// arp_scan_detector
// Tracks per-application sets of neighbor last octets and reports an id once
// its count of distinct octets passes the scan threshold.
// ----------------------------------------------------------------------------
//  channel   ports        direction  moves
//  req       req_*        in         one neighbor creation item
//  rsp       rsp_*        out        one result item per req item
//  csr       csr_*        in         register write (index, data)
//
//  Ignored items skip the sweep and go straight to the result. Flagged ids
//  and a full tracking table end after the sweep; other items then read and
//  update one map word and the entry count, after a clear when a new entry
//  is allocated: the id tables are swept one entry a cycle through their single
//  read ports, and a new entry clears its four map words one per cycle.
//  Reset is synchronous and clears valid bits and registers; no clearing pass.
//  A waiting result does not block the next item until its own result is due.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_scan_detector #(
   parameter int TRACK_ENTRIES   = 16,
   parameter int FLAGGED_ENTRIES = 16
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  arpsd_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output arpsd_pkg::rsp_type             rsp_data,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire [arpsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [arpsd_pkg::CSR_DATA_W-1:0] csr_data
);
   import arpsd_pkg::*;

   localparam int TW        = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
   localparam int FW        = (FLAGGED_ENTRIES > 1) ? $clog2(FLAGGED_ENTRIES) : 1;
   localparam int SCAN_N    = (TRACK_ENTRIES > FLAGGED_ENTRIES) ? TRACK_ENTRIES
                                                                : FLAGGED_ENTRIES;
   localparam int CW        = $clog2(SCAN_N + 1);
   localparam int MW        = TW + 2;
   localparam int MAP_DEPTH = 4 * TRACK_ENTRIES;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_CLEAR, S_READ, S_MODIFY, S_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [8:0] thr_ff;
   logic [7:0] loop_ff, mlow_ff, mhigh_ff;

   // item context
   req_type    item_ff;
   logic [TW-1:0] slot_ff;
   logic          new_ff;
   logic [1:0]    word_ff;
   rsp_type       pend_ff;

   // sweep
   logic [CW-1:0] sweep_ff, cmp_idx_ff;
   logic          cmp_vld_ff;
   logic          flag_hit_ff, found_ff, free_ff, ffree_ff;
   logic [TW-1:0] found_slot_ff, free_slot_ff;
   logic [FW-1:0] ffree_slot_ff;

   // valid bits
   logic [TRACK_ENTRIES-1:0]   track_valid_ff;
   logic [FLAGGED_ENTRIES-1:0] flagged_valid_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // memories
   logic [31:0] tid_mem  [TRACK_ENTRIES];
   logic [31:0] fid_mem  [FLAGGED_ENTRIES];
   logic [63:0] map_mem  [MAP_DEPTH];
   logic [8:0]  cnt_mem  [TRACK_ENTRIES];
   logic [31:0] tid_rd_ff, fid_rd_ff;
   logic [63:0] map_rd_ff;
   logic [8:0]  cnt_rd_ff;

   logic          issue;
   logic          t_in, f_in, t_valid, f_valid;
   logic          req_take, ignore_in;
   logic [7:0]    first_oct;
   logic [1:0]    oct_hi;
   logic [5:0]    oct_lo;
   logic          tid_we, fid_we, map_we, cnt_we;
   logic [MW-1:0] map_waddr, map_raddr;
   logic [63:0]   map_wdata, new_word;
   logic          bit_hit, report;
   logic [8:0]    cnt_base, cnt_next;

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign first_oct = req_data.next_hop[31:24];
   assign ignore_in = (first_oct == loop_ff) ||
                      ((first_oct > mlow_ff) && (first_oct < mhigh_ff));

   assign oct_hi = item_ff.next_hop[7:6];
   assign oct_lo = item_ff.next_hop[5:0];

   assign issue   = (state_ff == S_SCAN) && (sweep_ff < CW'(SCAN_N));
   assign t_in    = cmp_idx_ff < CW'(TRACK_ENTRIES);
   assign f_in    = cmp_idx_ff < CW'(FLAGGED_ENTRIES);
   assign t_valid = t_in && track_valid_ff[cmp_idx_ff[TW-1:0]];
   assign f_valid = f_in && flagged_valid_ff[cmp_idx_ff[FW-1:0]];

   // read-modify-write of one map word and the entry count
   always_comb begin
      bit_hit  = map_rd_ff[oct_lo];
      new_word = map_rd_ff | (64'd1 << oct_lo);
      cnt_base = new_ff ? 9'd0 : cnt_rd_ff;
      cnt_next = (!bit_hit && (cnt_base != COUNT_MAX)) ? cnt_base + 9'd1 : cnt_base;
      report   = cnt_next > thr_ff;
   end

   always_comb begin
      tid_we    = (state_ff == S_DECIDE) && !flag_hit_ff && !found_ff && free_ff;
      map_we    = (state_ff == S_CLEAR) || (state_ff == S_MODIFY);
      cnt_we    = (state_ff == S_MODIFY);
      fid_we    = (state_ff == S_MODIFY) && report && ffree_ff;
      map_raddr = {slot_ff, oct_hi};
      if (state_ff == S_CLEAR) begin
         map_waddr = {slot_ff, word_ff};
         map_wdata = 64'd0;
      end else begin
         map_waddr = {slot_ff, oct_hi};
         map_wdata = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (tid_we) begin
         tid_mem[free_slot_ff] <= item_ff.app_id;
      end
      tid_rd_ff <= tid_mem[sweep_ff[TW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (fid_we) begin
         fid_mem[ffree_slot_ff] <= item_ff.app_id;
      end
      fid_rd_ff <= fid_mem[sweep_ff[FW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[map_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[slot_ff] <= cnt_next;
      end
      cnt_rd_ff <= cnt_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         thr_ff           <= RST_SCAN_THRESHOLD;
         loop_ff          <= RST_LOOPBACK_OCTET;
         mlow_ff          <= RST_MULTICAST_LOW;
         mhigh_ff         <= RST_MULTICAST_HIGH;
         track_valid_ff   <= '0;
         flagged_valid_ff <= '0;
         rsp_valid_ff     <= 1'b0;
         cmp_vld_ff       <= 1'b0;
         sweep_ff         <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CFG_SCAN_THRESHOLD: thr_ff   <= csr_data;
               CFG_LOOPBACK_OCTET: loop_ff  <= csr_data[7:0];
               CFG_MULTICAST_LOW:  mlow_ff  <= csr_data[7:0];
               CFG_MULTICAST_HIGH: mhigh_ff <= csr_data[7:0];
               default: ;
            endcase
         end

         if (rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  item_ff     <= req_data;
                  sweep_ff    <= '0;
                  cmp_vld_ff  <= 1'b0;
                  flag_hit_ff <= 1'b0;
                  found_ff    <= 1'b0;
                  free_ff     <= 1'b0;
                  ffree_ff    <= 1'b0;
                  if (ignore_in) begin
                     pend_ff  <= '{ST_IGNORED, 1'b0, 32'd0, 9'd0};
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (issue) begin
                  sweep_ff <= sweep_ff + CW'(1);
               end
               cmp_vld_ff <= issue;
               cmp_idx_ff <= sweep_ff;
               if (cmp_vld_ff) begin
                  if (f_valid && (fid_rd_ff == item_ff.app_id)) begin
                     flag_hit_ff <= 1'b1;
                  end
                  if (f_in && !f_valid && !ffree_ff) begin
                     ffree_ff      <= 1'b1;
                     ffree_slot_ff <= cmp_idx_ff[FW-1:0];
                  end
                  if (t_valid && (tid_rd_ff == item_ff.app_id) && !found_ff) begin
                     found_ff      <= 1'b1;
                     found_slot_ff <= cmp_idx_ff[TW-1:0];
                  end
                  if (t_in && !t_valid && !free_ff) begin
                     free_ff      <= 1'b1;
                     free_slot_ff <= cmp_idx_ff[TW-1:0];
                  end
                  if (cmp_idx_ff == CW'(SCAN_N - 1)) begin
                     state_ff <= S_DECIDE;
                  end
               end
            end
            S_DECIDE: begin
               if (flag_hit_ff) begin
                  pend_ff  <= '{ST_FLAGGED, 1'b0, 32'd0, 9'd0};
                  state_ff <= S_OUT;
               end else if (found_ff) begin
                  slot_ff  <= found_slot_ff;
                  new_ff   <= 1'b0;
                  state_ff <= S_READ;
               end else if (free_ff) begin
                  slot_ff                      <= free_slot_ff;
                  new_ff                       <= 1'b1;
                  word_ff                      <= 2'd0;
                  track_valid_ff[free_slot_ff] <= 1'b1;
                  state_ff                     <= S_CLEAR;
               end else begin
                  pend_ff  <= '{ST_FULL, 1'b0, 32'd0, 9'd0};
                  state_ff <= S_OUT;
               end
            end
            S_CLEAR: begin
               word_ff <= word_ff + 2'd1;
               if (word_ff == 2'd3) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_MODIFY;
            end
            S_MODIFY: begin
               if (report) begin
                  track_valid_ff[slot_ff] <= 1'b0;
                  if (ffree_ff) begin
                     flagged_valid_ff[ffree_slot_ff] <= 1'b1;
                  end
                  pend_ff <= '{ST_REPORTED, 1'b1, item_ff.app_id, cnt_next};
               end else begin
                  pend_ff <= '{(new_ff ? ST_NEW : ST_UPDATED), 1'b0, 32'd0, cnt_next};
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= pend_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_report_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.report_valid == (rsp_data_ff.status == ST_REPORTED)))
      else $error("report flag disagrees with status");

   a_no_id_without_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.report_valid) |-> (rsp_data_ff.reported_id == 32'd0))
      else $error("reported id set without a report");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("item taken while previous still in work");

   a_compare_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == S_SCAN))
      else $error("table compare outside the sweep");
`endif

endmodule

`default_nettype wire
